FILE: rtl/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared types, command and status structs, and saturation helper for the
// 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int unsigned IDX_W = 4;
  localparam int unsigned ACC_W = 64;

  typedef enum logic [1:0] {
    A_OPA,
    A_PROD,
    A_ELEM
  } opa_sel_e;

  typedef struct packed {
    logic             clip;
    logic [ACC_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] cof_addr;
    logic             ld_a;
    opa_sel_e         a_sel;
    logic             b_cof;
    logic             mul_start;
    logic             term_clr;
    logic             term_flag;
    logic             term_add;
    logic             term_neg;
    logic             cof_wr;
    logic             cof_neg;
    logic             det_clr;
    logic             det_flag;
    logic             det_add;
    logic             div_start;
    logic             out_load;
    logic [IDX_W-1:0] out_idx;
  } mi4_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic det_zero;
    logic out_free;
  } mi4_sts_t;

  // Turns a magnitude and a sign into a value clamped to [-(posmax+1), posmax].
  function automatic sat_t sat_mag(logic [ACC_W-1:0] m, logic neg,
                                   logic [ACC_W-1:0] posmax);
    sat_t         r;
    logic [ACC_W:0] lim;
    lim    = {1'b0, posmax} + {{ACC_W{1'b0}}, 1'b1};
    r.clip = 1'b0;
    r.val  = '0;
    if (!neg) begin
      if (m > posmax) begin
        r.val  = posmax;
        r.clip = 1'b1;
      end else begin
        r.val = m;
      end
    end else begin
      if ({1'b0, m} > lim) begin
        r.val  = '0 - lim[ACC_W-1:0];
        r.clip = 1'b1;
      end else begin
        r.val = '0 - m;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/matrix_inverse_4x4.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 fixed-point matrix inverse by adjugate and cofactor expansion.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   element_value_i
//   out      output     out_valid_o/out_stall_i inverse_value_o, row_index_o,
//                                               column_index_o, is_last_o,
//                                               singular_o, saturated_o
//
// Elements transfer at one per cycle; the block then stalls its input while
// one shared multiplier (196 products) and a radix-2 divider (one division
// per element of a non-singular matrix) do the work. Output stalls hold the
// controller only in its output state, before the next division or reload.
// Reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4
  import mi4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] inverse_value_o,
  output logic [1:0]                   row_index_o,
  output logic [1:0]                   column_index_o,
  output logic                         is_last_o,
  output logic                         singular_o,
  output logic                         saturated_o
);

  mi4_cmd_t cmd;
  mi4_sts_t sts;

  mi4_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mi4_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .element_value_i(element_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .inverse_value_o(inverse_value_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .is_last_o      (is_last_o),
    .singular_o     (singular_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: rtl/mi4_mul.sv
// ----------------------------------------------------------------------------
// mi4_mul
// Sequential 64x64 fixed-point multiplier: one 32x32 partial product per
// cycle, then a fraction shift with saturation.
// ----------------------------------------------------------------------------
module mi4_mul
  import mi4_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] a_i,
  input  logic signed [ACC_W-1:0] b_i,
  output logic                    busy_o,
  output logic signed [ACC_W-1:0] prod_o,
  output logic                    clip_o
);

  localparam logic [2:0] LastPh = 3'd4;

  logic               busy_q;
  logic [2:0]         ph_q;
  logic [ACC_W-1:0]   ua_q, ub_q;
  logic               neg_q;
  logic [2*ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]   prod_q;
  logic               clip_q;

  logic [31:0]        xa, xb;
  logic [63:0]        pp;
  logic [2*ACC_W-1:0] pp_sh;
  logic [2*ACC_W-1:0] sh;
  logic [ACC_W-1:0]   mag;
  sat_t               res;

  always_comb begin
    xa = ph_q[1] ? ua_q[63:32] : ua_q[31:0];
    xb = ph_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp = xa * xb;
    unique case (ph_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    sh  = acc_q >> FRAC_BITS;
    mag = (|sh[2*ACC_W-1:ACC_W]) ? '1 : sh[ACC_W-1:0];
    res = sat_mag(mag, neg_q, {1'b0, {(ACC_W-1){1'b1}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      ph_q   <= '0;
    end else if (busy_q) begin
      if (ph_q == LastPh) begin
        busy_q <= 1'b0;
      end
      ph_q <= ph_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[ACC_W-1] ? ('0 - a_i) : a_i;
      ub_q  <= b_i[ACC_W-1] ? ('0 - b_i) : b_i;
      neg_q <= a_i[ACC_W-1] ^ b_i[ACC_W-1];
      acc_q <= '0;
    end else if (busy_q && ph_q != LastPh) begin
      acc_q <= acc_q + pp_sh;
    end
    if (busy_q && ph_q == LastPh) begin
      prod_q <= res.val;
      clip_q <= res.clip;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;
  assign clip_o = clip_q;

endmodule

FILE: rtl/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div
// Radix-2 restoring divider for (num << FRAC_BITS) / den on magnitudes,
// one quotient bit per cycle, clamped to the DATA_WIDTH signed range.
// ----------------------------------------------------------------------------
module mi4_div
  import mi4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [ACC_W-1:0]      num_i,
  input  logic signed [ACC_W-1:0]      den_i,
  output logic                         busy_o,
  output logic signed [DATA_WIDTH-1:0] quot_o,
  output logic                         clip_o
);

  localparam logic [ACC_W-1:0] PosMax = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

  logic                  busy_q;
  logic [7:0]            cnt_q;
  logic [2*ACC_W-1:0]    dvd_q;
  logic [ACC_W-1:0]      ud_q, rem_q, qlo_q;
  logic                  ovf_q, neg_q;
  logic [DATA_WIDTH-1:0] quot_q;
  logic                  clip_q;

  logic [ACC_W-1:0] un;
  logic [ACC_W:0]   r2;
  logic             qbit;
  sat_t             res;

  always_comb begin
    un   = num_i[ACC_W-1] ? ('0 - num_i) : num_i;
    r2   = {rem_q, dvd_q[2*ACC_W-1]};
    qbit = r2 >= {1'b0, ud_q};
    res  = sat_mag(ovf_q ? '1 : qlo_q, neg_q, PosMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q[7]) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {{ACC_W{1'b0}}, un} << FRAC_BITS;
      ud_q  <= den_i[ACC_W-1] ? ('0 - den_i) : den_i;
      rem_q <= '0;
      qlo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[ACC_W-1] ^ den_i[ACC_W-1];
    end else if (busy_q && !cnt_q[7]) begin
      dvd_q <= {dvd_q[2*ACC_W-2:0], 1'b0};
      rem_q <= qbit ? 64'(r2 - {1'b0, ud_q}) : r2[ACC_W-1:0];
      ovf_q <= ovf_q | qlo_q[ACC_W-1];
      qlo_q <= {qlo_q[ACC_W-2:0], qbit};
    end else if (busy_q) begin
      quot_q <= res.val[DATA_WIDTH-1:0];
      clip_q <= res.clip;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign clip_o = clip_q;

endmodule

FILE: rtl/mi4_dp.sv
// ----------------------------------------------------------------------------
// mi4_dp
// Datapath: element and cofactor memories, term and determinant
// accumulators, shared multiplier and divider, and the output register.
// ----------------------------------------------------------------------------
module mi4_dp
  import mi4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mi4_cmd_t                     cmd_i,
  output mi4_sts_t                     sts_o,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] inverse_value_o,
  output logic [1:0]                   row_index_o,
  output logic [1:0]                   column_index_o,
  output logic                         is_last_o,
  output logic                         singular_o,
  output logic                         saturated_o
);

  localparam logic [ACC_W-1:0] MaxVal = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] MinVal = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic sat_t add_sat(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    sat_t             r;
    logic [ACC_W-1:0] s;
    s      = a + b;
    r.clip = 1'b0;
    r.val  = s;
    if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) begin
      r.val  = MaxVal;
      r.clip = 1'b1;
    end else if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) begin
      r.val  = MinVal;
      r.clip = 1'b1;
    end
    return r;
  endfunction

  function automatic sat_t neg_sat(logic [ACC_W-1:0] a);
    sat_t r;
    if (a == MinVal) begin
      r.val  = MaxVal;
      r.clip = 1'b1;
    end else begin
      r.val  = '0 - a;
      r.clip = 1'b0;
    end
    return r;
  endfunction

  logic signed [DATA_WIDTH-1:0] elem_mem [16];
  logic signed [DATA_WIDTH-1:0] elem_q;
  sat_t                         cof_mem  [16];
  sat_t                         cof_q;

  logic signed [ACC_W-1:0] opa_q;
  logic signed [ACC_W-1:0] elem_ext;
  logic signed [ACC_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] prod;
  logic                    prod_clip, mul_busy;

  logic [ACC_W-1:0] term_q, det_q;
  logic             term_clip_q, det_clip_q;
  sat_t             term_in, term_sum, cof_in, det_sum;

  logic signed [DATA_WIDTH-1:0] quot;
  logic                         quot_clip, div_busy;

  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] out_value_q;
  logic [1:0]                   out_row_q, out_col_q;
  logic                         out_last_q, out_sing_q, out_sat_q;
  logic                         det_zero;

  assign elem_ext = ACC_W'(elem_q);

  always_comb begin
    unique case (cmd_i.a_sel)
      A_OPA:   mul_a = opa_q;
      A_PROD:  mul_a = prod;
      default: mul_a = elem_ext;
    endcase
    mul_b    = cmd_i.b_cof ? cof_q.val : elem_ext;
    term_in  = cmd_i.term_neg ? neg_sat(prod) : sat_t'{clip: 1'b0, val: prod};
    term_sum = add_sat(term_q, term_in.val);
    cof_in   = cmd_i.cof_neg ? neg_sat(term_q) : sat_t'{clip: 1'b0, val: term_q};
    det_sum  = add_sat(det_q, prod);
  end

  assign det_zero = det_q == '0;

  mi4_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .prod_o (prod),
    .clip_o (prod_clip)
  );

  mi4_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (cof_q.val),
    .den_i  (det_q),
    .busy_o (div_busy),
    .quot_o (quot),
    .clip_o (quot_clip)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      elem_mem[cmd_i.wr_addr] <= element_value_i;
    end
    elem_q <= elem_mem[cmd_i.rd_addr];
    if (cmd_i.cof_wr) begin
      cof_mem[cmd_i.cof_addr] <= '{clip: term_clip_q | cof_in.clip, val: cof_in.val};
    end
    cof_q <= cof_mem[cmd_i.cof_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      opa_q <= elem_ext;
    end
    if (cmd_i.term_clr) begin
      term_q      <= '0;
      term_clip_q <= 1'b0;
    end else if (cmd_i.term_add) begin
      term_q      <= term_sum.val;
      term_clip_q <= term_clip_q | prod_clip | term_in.clip | term_sum.clip;
    end else if (cmd_i.term_flag) begin
      term_clip_q <= term_clip_q | prod_clip;
    end
    if (cmd_i.det_clr) begin
      det_q      <= '0;
      det_clip_q <= 1'b0;
    end else if (cmd_i.det_add) begin
      det_q      <= det_sum.val;
      det_clip_q <= det_clip_q | prod_clip | det_sum.clip;
    end else if (cmd_i.det_flag) begin
      det_clip_q <= det_clip_q | cof_q.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= det_zero ? '0 : quot;
      out_row_q   <= cmd_i.out_idx[3:2];
      out_col_q   <= cmd_i.out_idx[1:0];
      out_last_q  <= &cmd_i.out_idx;
      out_sing_q  <= det_zero;
      out_sat_q   <= !det_zero && (det_clip_q || cof_q.clip || quot_clip);
    end
  end

  assign sts_o = '{mul_busy: mul_busy, div_busy: div_busy, det_zero: det_zero,
                   out_free: !out_valid_q || !out_stall_i};

  assign out_valid_o     = out_valid_q;
  assign inverse_value_o = out_value_q;
  assign row_index_o     = out_row_q;
  assign column_index_o  = out_col_q;
  assign is_last_o       = out_last_q;
  assign singular_o      = out_sing_q;
  assign saturated_o     = out_sat_q;

endmodule

FILE: rtl/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl
// Controller: sequences element loading, the six three-factor terms of every
// 3x3 cofactor, the determinant expansion and the sixteen divisions, which are skipped when the determinant is zero.
// ----------------------------------------------------------------------------
module mi4_ctrl
  import mi4_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mi4_sts_t sts_i,
  output mi4_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_LOAD, S_RD0, S_RD1, S_MUL1, S_WAIT1, S_MUL2, S_WAIT2, S_ACC, S_COF,
    S_DRD, S_DMUL, S_DWAIT, S_DACC, S_QRD, S_QSTART, S_QWAIT, S_OUT
  } state_e;

  localparam logic [2:0] LastTerm = 3'd5;
  localparam logic [2:0] FirstNeg = 3'd3;

  // Minor row and column of each factor of each det3 term, factor 0 first.
  function automatic logic [11:0] term_map(logic [2:0] k);
    logic [11:0] m;
    unique case (k)
      3'd0:    m = {2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
      3'd1:    m = {2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2};
      3'd2:    m = {2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
      3'd3:    m = {2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2};
      3'd4:    m = {2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2};
      3'd5:    m = {2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2};
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] elem_idx(logic [3:0] n, logic [2:0] k, logic [1:0] f);
    logic [11:0] m;
    logic [3:0]  rc;
    logic [1:0]  rr, cc;
    m = term_map(k);
    unique case (f)
      2'd0:    rc = m[11:8];
      2'd1:    rc = m[7:4];
      default: rc = m[3:0];
    endcase
    rr = rc[3:2] + {1'b0, rc[3:2] >= n[3:2]};
    cc = rc[1:0] + {1'b0, rc[1:0] >= n[1:0]};
    return {rr, cc};
  endfunction

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] k_q, k_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.a_sel    = A_ELEM;
    cmd_o.wr_addr  = cnt_q;
    cmd_o.cof_addr = cnt_q;
    cmd_o.out_idx  = cnt_q;
    cmd_o.rd_addr  = cnt_q;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.wr_en = in_valid_i;
        if (in_valid_i) begin
          cnt_d = cnt_q + 4'd1;
          if (&cnt_q) begin
            k_d     = '0;
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        cmd_o.rd_addr  = elem_idx(cnt_q, k_q, 2'd0);
        cmd_o.term_clr = k_q == '0;
        state_d        = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_addr = elem_idx(cnt_q, k_q, 2'd1);
        cmd_o.ld_a    = 1'b1;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.rd_addr   = elem_idx(cnt_q, k_q, 2'd2);
        cmd_o.a_sel     = A_OPA;
        cmd_o.mul_start = 1'b1;
        state_d         = S_WAIT1;
      end
      S_WAIT1: begin
        cmd_o.rd_addr = elem_idx(cnt_q, k_q, 2'd2);
        if (!sts_i.mul_busy) begin
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd_o.a_sel     = A_PROD;
        cmd_o.mul_start = 1'b1;
        cmd_o.term_flag = 1'b1;
        state_d         = S_WAIT2;
      end
      S_WAIT2: begin
        if (!sts_i.mul_busy) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.term_add = 1'b1;
        cmd_o.term_neg = k_q >= FirstNeg;
        if (k_q == LastTerm) begin
          k_d     = '0;
          state_d = S_COF;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_RD0;
        end
      end
      S_COF: begin
        cmd_o.cof_wr  = 1'b1;
        cmd_o.cof_neg = cnt_q[2] ^ cnt_q[0];
        cnt_d         = cnt_q + 4'd1;
        state_d       = (&cnt_q) ? S_DRD : S_RD0;
      end
      S_DRD: begin
        cmd_o.det_clr = cnt_q == '0;
        state_d       = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.b_cof     = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.det_flag  = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts_i.mul_busy) begin
          state_d = S_DACC;
        end
      end
      S_DACC: begin
        cmd_o.det_add = 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          state_d = S_QRD;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_DRD;
        end
      end
      S_QRD: begin
        cmd_o.cof_addr = {cnt_q[1:0], cnt_q[3:2]};
        state_d        = S_QSTART;
      end
      S_QSTART: begin
        cmd_o.cof_addr  = {cnt_q[1:0], cnt_q[3:2]};
        cmd_o.div_start = !sts_i.det_zero;
        state_d         = sts_i.det_zero ? S_OUT : S_QWAIT;
      end
      S_QWAIT: begin
        cmd_o.cof_addr = {cnt_q[1:0], cnt_q[3:2]};
        if (!sts_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.cof_addr = {cnt_q[1:0], cnt_q[3:2]};
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cnt_d          = cnt_q + 4'd1;
          state_d        = (&cnt_q) ? S_LOAD : S_QRD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  assign in_stall_o = state_q != S_LOAD;

endmodule
